// ----- rtl/core/ndpf_pkg.sv -----
// Shared constants and the darken function for the noisy darken pixel filter.
`default_nettype none
package ndpf_pkg;

  localparam int PIX_W            = 8;
  localparam int ROW_PIXELS_DEF   = 264;
  localparam int ROW_COUNT_DEF    = 184;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;
  localparam int OFFSET_W         = 16;

  localparam logic [PADDR_W-1:0] ADDR_NOISE_OFFSET = 3'd0;

  // keep high nibble, low nibble becomes (15*low + noise) >> 4
  function automatic logic [PIX_W-1:0] darken(input logic [PIX_W-1:0] p,
                                              input logic [3:0] noise);
    logic [7:0] lo;
    logic [7:0] sum;
    lo  = {4'b0, p[3:0]};
    sum = (lo << 4) - lo + {4'b0, noise};
    return {p[7:4], sum[7:4]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ndpf_line_mem.sv -----
// Line store: one row of filtered pixels, synchronous read with enable.
`default_nettype none
module ndpf_line_mem
  import ndpf_pkg::*;
#(
  parameter int DEPTH = ROW_PIXELS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [PIX_W-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [PIX_W-1:0]         wr_data
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next enabled read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/noisy_darken_pixel_filter.sv -----
// Noisy darken pixel filter: raster-order palette pixel darkening with noise.
// A pixel goes through the compute stage register and then the output register.
// Throughput: one pixel per cycle unless the output is stalled; the line store has one
// read and one write port, and the two-left dependence is met by two result registers.
// Reset clears the column and row counters, the last two results, noise_offset
// and all valid flags. The line store is not cleared; it is read only after written.
`default_nettype none
module noisy_darken_pixel_filter
  import ndpf_pkg::*;
#(
  parameter int ROW_PIXELS = ROW_PIXELS_DEF,
  parameter int ROW_COUNT  = ROW_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // APB configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [PIX_W-1:0]   pixel_in,
  input  wire logic [PIX_W-1:0]   left_border,
  input  wire logic [PIX_W-1:0]   above_right_border,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [PIX_W-1:0]   pixel_out,
  output logic                    row_done,
  output logic                    frame_done
);

  localparam int CW = $clog2(ROW_PIXELS);
  localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam logic [CW-1:0] LAST_COL = CW'(ROW_PIXELS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROW_COUNT - 1);
  localparam int RAMP_BASE_I = (((ROW_PIXELS - ROW_COUNT) % 64) + 64) % 64;
  localparam logic [5:0] RAMP_BASE = 6'(RAMP_BASE_I);

  // configuration
  logic [OFFSET_W-1:0] noise_offset;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_offset <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_NOISE_OFFSET) begin
      noise_offset <= pwdata[OFFSET_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_NOISE_OFFSET) begin
      prdata = {{(PDATA_W-OFFSET_W){1'b0}}, noise_offset};
    end
  end

  // stage 0: position, ramp and line store read
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          in_xfer;
  logic          last_col0;
  logic          last_row0;
  logic [CW-1:0] rd_addr;
  logic [5:0]    ramp6;

  assign in_xfer   = in_valid && !in_stall;
  assign last_col0 = (col == LAST_COL);
  assign last_row0 = (row == LAST_ROW);
  assign rd_addr   = last_col0 ? '0 : col + CW'(1);
  assign ramp6     = RAMP_BASE + 6'(row) - 6'(col) - noise_offset[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_xfer) begin
      if (last_col0) begin
        col <= '0;
        row <= last_row0 ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // stage 1: noise and darken
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [3:0]       s1_left;
  logic [3:0]       s1_arb;
  logic [3:0]       s1_ramp;
  logic [CW-1:0]    s1_col;
  logic             s1_first_row;
  logic             s1_early_col;
  logic             s1_last_col;
  logic             s1_last_row;
  logic             s1_advance;
  logic [PIX_W-1:0] rd_data;
  logic [PIX_W-1:0] recent0;
  logic [PIX_W-1:0] recent1;
  logic [3:0]       two_left;
  logic [3:0]       above;
  logic [3:0]       noise;
  logic [PIX_W-1:0] result;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix       <= pixel_in;
      s1_left      <= left_border[3:0];
      s1_arb       <= above_right_border[3:0];
      s1_ramp      <= ramp6[5:2];
      s1_col       <= col;
      s1_first_row <= (row == '0);
      s1_early_col <= (col < CW'(2));
      s1_last_col  <= last_col0;
      s1_last_row  <= last_row0;
    end
  end

  ndpf_line_mem #(
    .DEPTH (ROW_PIXELS)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (s1_advance),
    .wr_addr (s1_col),
    .wr_data (result)
  );

  always_comb begin
    two_left = s1_early_col ? s1_left : recent1[3:0];
    if (s1_first_row) begin
      above = '0;
    end else if (s1_last_col) begin
      above = s1_arb;
    end else begin
      above = rd_data[3:0];
    end
    noise  = s1_ramp + two_left + above;
    result = darken(s1_pix, noise);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent0 <= '0;
      recent1 <= '0;
    end else if (s1_advance) begin
      recent1 <= recent0;
      recent0 <= result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      pixel_out  <= result;
      row_done   <= s1_last_col;
      frame_done <= s1_last_col && s1_last_row;
    end
  end

  // checks
  a_frame_implies_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> row_done)
    else $error("frame_done without row_done");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col <= LAST_COL)
    else $error("column counter out of range");

  a_wrap_col: assert property (@(posedge clk) disable iff (rst)
    in_xfer && last_col0 |=> col == '0)
    else $error("column did not wrap after last column");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("result lost between compute stage and output");

endmodule
`default_nettype wire

// ----- sim/noisy_darken_pixel_filter_tb.sv -----
// Self-checking testbench for the noisy darken pixel filter, default region size.
module noisy_darken_pixel_filter_tb;
  import ndpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // region size matches the block's defaults
  localparam int TB_COLS = ROW_PIXELS_DEF;
  localparam int TB_ROWS = ROW_COUNT_DEF;
  localparam int NUM_SETTINGS = 8;
  localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] above;
  } pixel_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
  } filtered_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   pixel_in = '0;
  logic [PIX_W-1:0]   left_border = '0;
  logic [PIX_W-1:0]   above_right_border = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   pixel_out;
  logic               row_done;
  logic               frame_done;

  noisy_darken_pixel_filter #(
    .ROW_PIXELS(TB_COLS),
    .ROW_COUNT (TB_ROWS)
  ) dut (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .pixel_in          (pixel_in),
    .left_border       (left_border),
    .above_right_border(above_right_border),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .pixel_out         (pixel_out),
    .row_done          (row_done),
    .frame_done        (frame_done)
  );

  // predictor state
  logic [PIX_W-1:0]    prev_row_pix [TB_COLS];
  logic [PIX_W-1:0]    last_two [2];
  int                  col_pos = 0;
  int                  row_pos = 0;
  logic [OFFSET_W-1:0] ramp_offset = '0;

  pixel_item_t pixel_queue [$];
  filtered_t   expected_pixels [$];
  pixel_item_t next_item;
  filtered_t   want;

  bit in_taken = 1'b0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;
  int in_gap = 0;
  int stall_left = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int frames_seen = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // filters one pixel at the current raster position and advances it
  function automatic filtered_t filter_pixel(input logic [PIX_W-1:0] pix,
                                             input logic [PIX_W-1:0] left,
                                             input logic [PIX_W-1:0] above_border);
    filtered_t        res;
    logic [5:0]       ramp6;
    logic [PIX_W-1:0] two_left;
    logic [PIX_W-1:0] above;
    logic [3:0]       noise;
    logic [7:0]       dark_lo;
    bit               last_col;
    bit               last_row;
    last_col = (col_pos == TB_COLS - 1);
    last_row = (row_pos == TB_ROWS - 1);
    // ramp wraps modulo 64, so negative values fold into the range
    ramp6 = 6'(TB_COLS - TB_ROWS + row_pos - col_pos - int'(ramp_offset));
    two_left = (col_pos < 2) ? left : last_two[1];
    if (row_pos == 0) above = '0;
    else if (last_col) above = above_border;
    else above = prev_row_pix[col_pos + 1];
    noise = 4'(int'(ramp6[5:2]) + int'(two_left) + int'(above));
    dark_lo = 8'((int'(pix[3:0]) * 15 + int'(noise)) >> 4);
    res.pix = {pix[7:4], dark_lo[3:0]};
    res.row_end = last_col;
    res.frame_end = last_col && last_row;
    prev_row_pix[col_pos] = res.pix;
    last_two[1] = last_two[0];
    last_two[0] = res.pix;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_NOISE_OFFSET) ramp_offset = data[OFFSET_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_offset_readback();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_NOISE_OFFSET;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[OFFSET_W-1:0] !== ramp_offset)
      note_mismatch("noise_offset readback", ramp_offset, prdata[OFFSET_W-1:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // block is idle once every queued pixel went in and every result came out
  task automatic wait_idle();
    @(negedge clk);
    while (pixel_queue.size() != 0 || in_valid || items_sent != results_checked ||
           expected_pixels.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled transfer keeps its payload
    end else if (in_gap != 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (pixel_queue.size() != 0) begin
      next_item = pixel_queue.pop_front();
      pixel_in <= next_item.pix;
      left_border <= next_item.left;
      above_right_border <= next_item.above;
      in_valid <= 1'b1;
      items_sent++;
      if (in_gaps_on) in_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (out_stalls_on) stall_left = pick_gap();
    end
  end

  // predict on input transfers, check output transfers
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken)
      expected_pixels.push_back(filter_pixel(pixel_in, left_border, above_right_border));
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: output transfer with nothing expected: pixel_out=%h",
                   $realtime, pixel_out);
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (pixel_out !== want.pix)
          note_mismatch("pixel_out", 16'(want.pix), 16'(pixel_out));
        if (row_done !== want.row_end)
          note_mismatch("row_done", 16'(want.row_end), 16'(row_done));
        if (frame_done !== want.frame_end)
          note_mismatch("frame_done", 16'(want.frame_end), 16'(frame_done));
      end
      if (frame_done === 1'b1) frames_seen++;
    end
  end

  logic [OFFSET_W-1:0] offsets [NUM_SETTINGS] = '{16'h0000, 16'hffff, 16'h003f, 16'h0040,
                                                  16'h8000, 16'h0001, 16'h0000, 16'h0000};

  initial begin
    pixel_item_t item;
    int          count;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    offsets[6] = 16'($urandom);
    offsets[7] = 16'($urandom);
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p != 0) wait_idle();
      apb_write(ADDR_NOISE_OFFSET, {16'($urandom), offsets[p]});
      if (p % 3 == 1) apb_write(ADDR_UNUSED, $urandom);
      check_offset_readback();
      in_gaps_on = (p % 4 == 0) || (p % 4 == 1);
      out_stalls_on = (p % 4 == 0) || (p % 4 == 2);
      @(posedge clk);
      if (p == 0) begin
        // two rows: extreme pixels and borders, first columns and row ends
        for (int i = 0; i < 2 * TB_COLS; i++) begin
          case (i % 4)
            0: item.pix = 8'h00;
            1: item.pix = 8'hff;
            2: item.pix = 8'h0f;
            default: item.pix = 8'hf0;
          endcase
          item.left = (i % 2 == 0) ? 8'h00 : 8'hff;
          item.above = ((i / 2) % 2 == 0) ? 8'hff : 8'h00;
          pixel_queue.push_back(item);
        end
      end
      count = $urandom_range(120, 160);
      for (int i = 0; i < count; i++) begin
        item.pix = 8'($urandom);
        item.left = 8'($urandom);
        item.above = 8'($urandom);
        pixel_queue.push_back(item);
      end
    end
    wait_idle();
    repeat (10) @(posedge clk);
    $display("%0d pixels sent, %0d results checked, %0d frames of %0dx%0d completed",
             items_sent, results_checked, frames_seen, TB_COLS, TB_ROWS);
    $display("%0d noise offset settings, %0d mismatches", NUM_SETTINGS, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout: stream did not drain");
    $display("TEST FAILED");
    $finish;
  end

endmodule
